// ===== rtl/core/rotor_encoder_speed_meter_defines.svh =====
// Assertion helpers shared by the speed meter modules.
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef ROTOR_ENCODER_SPEED_METER_DEFINES_SVH
`define ROTOR_ENCODER_SPEED_METER_DEFINES_SVH

// Same-cycle implication, idle during reset.
`define RESM_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, idle during reset.
`define RESM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/resm_pkg.sv =====
package resm_pkg;

  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 24;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int unsigned REM_W   = 57;
  localparam int unsigned DVD_W   = 64;
  localparam int unsigned DVS_W   = 56;
  localparam int unsigned QUOT_W  = 35;
  localparam int unsigned STEP_W  = 6;

  localparam logic [MUL_B_W-1:0] MS_PER_MIN   = 24'd60000;
  localparam logic [MUL_B_W-1:0] MDEG_PER_REV = 24'd360000;
  localparam logic [MUL_B_W-1:0] CRPM_SCALE   = 24'd6000000;
  localparam logic [23:0]        RPM_MAX      = 24'hFFFFFF;

  localparam logic [STEP_W-1:0]  ANGLE_STEPS  = 6'd35;
  localparam logic [STEP_W-1:0]  RPM_STEPS    = 6'd24;

  localparam logic [15:0] GEAR_RESET   = 16'd100;
  localparam logic [15:0] PULSES_RESET = 16'd4096;

  localparam logic REG_GEAR   = 1'b0;
  localparam logic REG_PULSES = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CPR,
    ST_TIME,
    ST_ANGLE_MUL,
    ST_DELTA,
    ST_ANGLE_DIV,
    ST_SUM_LO,
    ST_SUM_HI,
    ST_DEN,
    ST_RPM_CHK,
    ST_RPM_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [REM_W-1:0]  rem;
    logic [DVD_W-1:0]  dvd;
    logic [DVS_W-1:0]  dvs;
    logic [STEP_W-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_stat_t;

endpackage

// ===== rtl/core/resm_mul.sv =====
module resm_mul (
  input  logic                          clk,
  input  logic [resm_pkg::MUL_A_W-1:0]  a,
  input  logic [resm_pkg::MUL_B_W-1:0]  b,
  output logic [resm_pkg::MUL_P_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= resm_pkg::MUL_P_W'(a) * resm_pkg::MUL_P_W'(b);
  end

endmodule

// ===== rtl/core/resm_div.sv =====
`include "rotor_encoder_speed_meter_defines.svh"

module resm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  resm_pkg::div_cmd_t  cmd,
  output resm_pkg::div_stat_t stat
);

  logic                          busy_r;
  logic                          done_r;
  logic [resm_pkg::STEP_W-1:0]   cnt_r;
  logic [resm_pkg::REM_W-1:0]    p_r;
  logic [resm_pkg::DVD_W-1:0]    dvd_r;
  logic [resm_pkg::DVS_W-1:0]    dvs_r;
  logic [resm_pkg::QUOT_W-1:0]   q_r;

  logic [resm_pkg::REM_W-1:0]    p_sh;
  logic [resm_pkg::REM_W-1:0]    p_nxt;
  logic                          ge;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    p_sh  = {p_r[resm_pkg::REM_W-2:0], dvd_r[resm_pkg::DVD_W-1]};
    ge    = p_sh >= {1'b0, dvs_r};
    p_nxt = ge ? (p_sh - {1'b0, dvs_r}) : p_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= cmd.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == resm_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      p_r   <= cmd.rem;
      dvd_r <= cmd.dvd;
      dvs_r <= cmd.dvs;
      q_r   <= '0;
    end else if (busy_r) begin
      p_r   <= p_nxt;
      dvd_r <= {dvd_r[resm_pkg::DVD_W-2:0], 1'b0};
      q_r   <= {q_r[resm_pkg::QUOT_W-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.quot = q_r;

  `RESM_ASSERT(a_div_no_restart, cmd.start, !busy_r, "divider restarted while busy")
  `RESM_ASSERT(a_div_rem_bound, busy_r, p_r < {1'b0, dvs_r}, "remainder not below divisor")
  `RESM_ASSERT_NEXT(a_div_done_idle, busy_r && cnt_r == resm_pkg::STEP_W'(1), done_r && !busy_r,
                    "divider did not finish on its last step")

endmodule

// ===== rtl/core/rotor_encoder_speed_meter.sv =====
// Rotor encoder speed meter.
// Input channel (in_valid / in_stall): one rotor sample per item, a minute,
// a millisecond count and an absolute encoder count. Result channel
// (out_valid / out_stall): one item per sample with the time in ms, the
// angle in millidegrees and, every WINDOW samples, the speed in centi-rpm.
// Configuration: cfg_we writes gear_ratio (index 0) or encoder_pulses
// (index 1) from cfg_wdata; write only while no sample is in flight.
// Datapath: one shared 32x24 multiplier and one bit-per-cycle restoring
// divider do all the arithmetic. A sample that does not close a window
// runs 35 angle division steps; a sample that closes one with a positive
// interval and an unsaturated speed runs another 24 division steps for the
// speed; with zero counts per revolution both divisions are skipped.
// in_stall is high from acceptance until the result is registered, so a
// new sample is taken only after the last one has finished.
// A result waits in the output register while out_stall is high; the next
// sample is still accepted and processed, and it holds in its last step
// until the output register frees up.
// Reset (rst_n low, synchronous) restores gear_ratio 100, encoder_pulses
// 4096 and clears the previous count, the window sum, start time and tally.
`include "rotor_encoder_speed_meter_defines.svh"

module rotor_encoder_speed_meter #(
  parameter int unsigned WINDOW = 50
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_sample_minute,
  input  logic [15:0] in_sample_msec,
  input  logic [15:0] in_encoder_count,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_time_ms,
  output logic [34:0] out_angle_mdeg,
  output logic [23:0] out_rpm_centi,
  output logic        out_rpm_valid,
  output logic        out_bad_interval
);

  resm_pkg::state_t state_r, state_nxt;

  logic [15:0] gear_r, pulses_r;
  logic [15:0] last_count_r;
  logic [39:0] dsum_r;
  logic [23:0] wstart_r;
  logic [7:0]  tally_r;

  logic [7:0]  min_r;
  logic [15:0] msec_r;
  logic [15:0] count_r;
  logic [31:0] cpr_r;
  logic [23:0] time_r;
  logic [39:0] rsum_r;
  logic        close_r;
  logic        rpm_go_r;
  logic        bad_r;
  logic [23:0] dt_r;
  logic [42:0] lo_r;
  logic [63:0] num_r;
  logic [34:0] angle_r;
  logic [23:0] rpm_r;

  logic        out_valid_r;
  logic [23:0] out_time_ms_r;
  logic [34:0] out_angle_mdeg_r;
  logic [23:0] out_rpm_centi_r;
  logic        out_rpm_valid_r;
  logic        out_bad_interval_r;

  logic [resm_pkg::MUL_A_W-1:0] mul_a;
  logic [resm_pkg::MUL_B_W-1:0] mul_b;
  logic [resm_pkg::MUL_P_W-1:0] prod;
  resm_pkg::div_cmd_t           div_cmd;
  resm_pkg::div_stat_t          div_stat;

  logic        accept;
  logic        slot_free;
  logic        cpr_zero;
  logic        rpm_sat;
  logic [16:0] diff;
  logic [32:0] wrapped;
  logic [31:0] udelta;
  logic [40:0] sum_raw;
  logic [39:0] sum_sat;
  logic [39:0] udelta_sum;
  logic [8:0]  tally_inc;
  logic        close;
  logic [24:0] dt_s;
  logic        dt_pos;

  resm_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  resm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd),
    .stat  (div_stat)
  );

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != resm_pkg::ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign cpr_zero  = (cpr_r == '0);
  assign rpm_sat   = {16'b0, num_r[63:24]} >= prod;

  // Encoder delta, window sum and window close, used in the delta step.
  always_comb begin
    diff    = {1'b0, count_r} - {1'b0, last_count_r};
    wrapped = {{16{diff[16]}}, diff} + {1'b0, cpr_r};
    if (!diff[16]) begin
      udelta = {16'b0, diff[15:0]};
    end else if (!wrapped[32]) begin
      udelta = wrapped[31:0];
    end else begin
      udelta = '0;
    end
    sum_raw    = {1'b0, dsum_r} + {9'b0, udelta};
    sum_sat    = sum_raw[40] ? {40{1'b1}} : sum_raw[39:0];
    udelta_sum = {8'b0, udelta};
    tally_inc  = {1'b0, tally_r} + 9'd1;
    close      = tally_inc >= 9'(WINDOW);
    dt_s       = {1'b0, time_r} - {1'b0, wstart_r};
    dt_pos     = !dt_s[24] && (dt_s != '0);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      resm_pkg::ST_IDLE:      if (in_valid) state_nxt = resm_pkg::ST_CPR;
      resm_pkg::ST_CPR:       state_nxt = resm_pkg::ST_TIME;
      resm_pkg::ST_TIME:      state_nxt = resm_pkg::ST_ANGLE_MUL;
      resm_pkg::ST_ANGLE_MUL: state_nxt = resm_pkg::ST_DELTA;
      resm_pkg::ST_DELTA:
        state_nxt = cpr_zero ? resm_pkg::ST_DONE : resm_pkg::ST_ANGLE_DIV;
      resm_pkg::ST_ANGLE_DIV:
        if (div_stat.done) begin
          state_nxt = rpm_go_r ? resm_pkg::ST_SUM_LO : resm_pkg::ST_DONE;
        end
      resm_pkg::ST_SUM_LO:    state_nxt = resm_pkg::ST_SUM_HI;
      resm_pkg::ST_SUM_HI:    state_nxt = resm_pkg::ST_DEN;
      resm_pkg::ST_DEN:       state_nxt = resm_pkg::ST_RPM_CHK;
      resm_pkg::ST_RPM_CHK:
        state_nxt = rpm_sat ? resm_pkg::ST_DONE : resm_pkg::ST_RPM_DIV;
      resm_pkg::ST_RPM_DIV:   if (div_stat.done) state_nxt = resm_pkg::ST_DONE;
      resm_pkg::ST_DONE:      if (slot_free) state_nxt = resm_pkg::ST_IDLE;
      default:                state_nxt = resm_pkg::ST_IDLE;
    endcase
  end

  // Operand selection for the shared multiplier and divider.
  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    div_cmd       = '0;
    unique case (state_r)
      resm_pkg::ST_CPR: begin
        mul_a = {16'b0, gear_r};
        mul_b = {8'b0, pulses_r};
      end
      resm_pkg::ST_TIME: begin
        mul_a = {24'b0, min_r};
        mul_b = resm_pkg::MS_PER_MIN;
      end
      resm_pkg::ST_ANGLE_MUL: begin
        mul_a = {16'b0, count_r};
        mul_b = resm_pkg::MDEG_PER_REV;
      end
      resm_pkg::ST_DELTA: begin
        div_cmd.start = !cpr_zero;
        div_cmd.rem   = '0;
        div_cmd.dvd   = {prod[34:0], 29'b0};
        div_cmd.dvs   = {24'b0, cpr_r};
        div_cmd.steps = resm_pkg::ANGLE_STEPS;
      end
      resm_pkg::ST_SUM_LO: begin
        mul_a = {12'b0, rsum_r[19:0]};
        mul_b = resm_pkg::CRPM_SCALE;
      end
      resm_pkg::ST_SUM_HI: begin
        mul_a = {12'b0, rsum_r[39:20]};
        mul_b = resm_pkg::CRPM_SCALE;
      end
      resm_pkg::ST_DEN: begin
        mul_a = cpr_r;
        mul_b = dt_r;
      end
      resm_pkg::ST_RPM_CHK: begin
        // Quotient fits 24 bits here, so the top of the numerator is the
        // starting remainder and only the low 24 bits are shifted in.
        div_cmd.start = !rpm_sat;
        div_cmd.rem   = {17'b0, num_r[63:24]};
        div_cmd.dvd   = {num_r[23:0], 40'b0};
        div_cmd.dvs   = prod;
        div_cmd.steps = resm_pkg::RPM_STEPS;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= resm_pkg::ST_IDLE;
      gear_r       <= resm_pkg::GEAR_RESET;
      pulses_r     <= resm_pkg::PULSES_RESET;
      last_count_r <= '0;
      dsum_r       <= '0;
      wstart_r     <= '0;
      tally_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          resm_pkg::REG_GEAR:   gear_r   <= cfg_wdata;
          resm_pkg::REG_PULSES: pulses_r <= cfg_wdata;
          default:              gear_r   <= gear_r;
        endcase
      end
      if (state_r == resm_pkg::ST_DELTA) begin
        last_count_r <= count_r;
        if (close) begin
          dsum_r   <= udelta_sum;
          wstart_r <= time_r;
          tally_r  <= '0;
        end else begin
          dsum_r  <= sum_sat;
          tally_r <= tally_inc[7:0];
        end
      end
      if (state_r == resm_pkg::ST_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      min_r   <= in_sample_minute;
      msec_r  <= in_sample_msec;
      count_r <= in_encoder_count;
    end
    unique case (state_r)
      resm_pkg::ST_TIME:      cpr_r  <= prod[31:0];
      resm_pkg::ST_ANGLE_MUL: time_r <= prod[23:0] + {8'b0, msec_r};
      resm_pkg::ST_DELTA: begin
        rsum_r   <= sum_sat;
        close_r  <= close;
        rpm_go_r <= close && dt_pos;
        bad_r    <= close && !dt_pos;
        dt_r     <= dt_s[23:0];
        angle_r  <= '0;
        rpm_r    <= '0;
      end
      resm_pkg::ST_ANGLE_DIV: if (div_stat.done) angle_r <= div_stat.quot;
      resm_pkg::ST_SUM_HI:    lo_r  <= prod[42:0];
      resm_pkg::ST_DEN:       num_r <= {1'b0, prod[42:0], 20'b0} + {21'b0, lo_r};
      resm_pkg::ST_RPM_CHK:   if (rpm_sat) rpm_r <= resm_pkg::RPM_MAX;
      resm_pkg::ST_RPM_DIV:   if (div_stat.done) rpm_r <= div_stat.quot[23:0];
      default:                lo_r <= lo_r;
    endcase
    if (state_r == resm_pkg::ST_DONE && slot_free) begin
      out_time_ms_r      <= time_r;
      out_angle_mdeg_r   <= angle_r;
      out_rpm_centi_r    <= rpm_r;
      out_rpm_valid_r    <= close_r;
      out_bad_interval_r <= bad_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_time_ms      = out_time_ms_r;
  assign out_angle_mdeg   = out_angle_mdeg_r;
  assign out_rpm_centi    = out_rpm_centi_r;
  assign out_rpm_valid    = out_rpm_valid_r;
  assign out_bad_interval = out_bad_interval_r;

  `RESM_ASSERT(a_tally_bound, 1'b1, tally_r < 8'(WINDOW), "window tally reached WINDOW")
  `RESM_ASSERT(a_rpm_zero_open, out_valid_r && !out_rpm_valid_r, out_rpm_centi_r == '0,
               "speed nonzero without a closed window")
  `RESM_ASSERT(a_bad_closed, out_valid_r && out_bad_interval_r,
               out_rpm_valid_r && out_rpm_centi_r == '0, "bad interval with speed or open window")
  `RESM_ASSERT_NEXT(a_result_posted, state_r == resm_pkg::ST_DONE && slot_free, out_valid_r,
                    "finished sample not posted")
  `RESM_ASSERT(a_div_idle, state_r == resm_pkg::ST_IDLE, !div_stat.busy,
               "divider busy with no sample in flight")

endmodule
